/* rtl/oale_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the ordered list engine.
package oale_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned KIND_W = 2;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [VAL_W-1:0] GET_FAIL_VALUE = 32'd65539;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOCATE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_GET    = 2'd3;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_TOP,
    IDX_POS,
    IDX_POS_M1,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef enum logic [1:0] {
    WA_IDX_P1,
    WA_IDX_M1,
    WA_POS_M1
  } wr_sel_e;

  typedef struct packed {
    logic    accept;
    idx_op_e idx_op;
    logic    rd_en;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_ok;
    logic    set_found;
    logic    set_rd;
    logic    set_fail_rd;
    logic    publish;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              ins_ok;
    logic              ins_moves;
    logic              del_ok;
    logic              del_moves;
    logic              get_ok;
    logic              cnt_zero;
    logic              idx_at_pos_m1;
    logic              idx_at_top;
    logic              match;
    logic              out_free;
  } status_t;

endpackage

/* rtl/oale_dpath.sv */
// Datapath of the ordered list engine: element memory, index, count and result registers.
module oale_dpath
  import oale_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [POS_W-1:0]      position_i,
  input  logic [VAL_W-1:0]      value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);

  logic [VAL_W-1:0]  mem [CAPACITY];
  logic [VAL_W-1:0]  rdata_q;

  logic [KIND_W-1:0] kind_q;
  logic [POS_W-1:0]  pos_q;
  logic [VAL_W-1:0]  val_q;

  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              res_ok_q, res_ok_d;
  logic [POS_W-1:0]  res_found_q, res_found_d;
  logic [VAL_W-1:0]  res_rd_q, res_rd_d;

  logic              out_valid_q, out_valid_d;
  logic              out_ok_q;
  logic [POS_W-1:0]  out_found_q;
  logic [VAL_W-1:0]  out_rd_q;
  logic [POS_W-1:0]  out_len_q;
  logic              out_empty_q;

  logic [CMP_W-1:0]  pos_w, cnt_w, idx_inc_w;
  logic [ADDR_W-1:0] wr_addr;
  logic [VAL_W-1:0]  wr_data;

  assign pos_w     = CMP_W'(pos_q);
  assign cnt_w     = CMP_W'(cnt_q);
  assign idx_inc_w = CMP_W'(idx_q) + CMP_W'(1);

  always_comb begin
    status_o.kind          = kind_q;
    status_o.ins_ok        = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1)) && (cnt_q < CapCnt);
    status_o.ins_moves     = (pos_w <= cnt_w);
    status_o.del_ok        = (pos_w != '0) && (pos_w <= cnt_w);
    status_o.del_moves     = (pos_w < cnt_w);
    status_o.get_ok        = (pos_w != '0) && (pos_w <= cnt_w);
    status_o.cnt_zero      = (cnt_q == '0);
    status_o.idx_at_pos_m1 = (idx_inc_w == pos_w);
    status_o.idx_at_top    = (idx_inc_w == cnt_w);
    status_o.match         = (rdata_q == val_q);
    status_o.out_free      = !out_valid_q || out_ready_i;
  end

  always_comb begin
    case (cmd_i.idx_op)
      IDX_HOLD:   idx_d = idx_q;
      IDX_TOP:    idx_d = ADDR_W'(cnt_q - CNT_W'(1));
      IDX_POS:    idx_d = ADDR_W'(pos_w);
      IDX_POS_M1: idx_d = ADDR_W'(pos_w - CMP_W'(1));
      IDX_ZERO:   idx_d = '0;
      IDX_INC:    idx_d = idx_q + ADDR_W'(1);
      IDX_DEC:    idx_d = idx_q - ADDR_W'(1);
      default:    idx_d = idx_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      WA_IDX_P1: begin
        wr_addr = idx_q + ADDR_W'(1);
        wr_data = rdata_q;
      end
      WA_IDX_M1: begin
        wr_addr = idx_q - ADDR_W'(1);
        wr_data = rdata_q;
      end
      WA_POS_M1: begin
        wr_addr = ADDR_W'(pos_w - CMP_W'(1));
        wr_data = val_q;
      end
      default: begin
        wr_addr = idx_q;
        wr_data = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[idx_d];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_comb begin
    res_ok_d    = res_ok_q;
    res_found_d = res_found_q;
    res_rd_d    = res_rd_q;
    if (cmd_i.accept) begin
      res_ok_d    = 1'b0;
      res_found_d = '0;
      res_rd_d    = '0;
    end
    if (cmd_i.set_ok) begin
      res_ok_d = 1'b1;
    end
    if (cmd_i.set_found) begin
      res_found_d = POS_W'(idx_inc_w);
    end
    if (cmd_i.set_rd) begin
      res_rd_d = rdata_q;
    end
    if (cmd_i.set_fail_rd) begin
      res_rd_d = GET_FAIL_VALUE;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    res_ok_q    <= res_ok_d;
    res_found_q <= res_found_d;
    res_rd_q    <= res_rd_d;
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      pos_q  <= position_i;
      val_q  <= value_i;
    end
    if (cmd_i.publish) begin
      out_ok_q    <= res_ok_q;
      out_found_q <= res_found_q;
      out_rd_q    <= res_rd_q;
      out_len_q   <= POS_W'(cnt_q);
      out_empty_q <= (cnt_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_empty_q, out_len_q, out_rd_q, out_found_q, out_ok_q};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapCnt)
    else $error("Entry count exceeds the capacity.");

  a_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en && cmd_i.rd_en |-> wr_addr != idx_d)
    else $error("Memory read and write hit the same entry in one cycle.");

  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("Entry count did not grow by one after an insert.");

endmodule

/* rtl/oale_ctrl.sv */
// Controller state machine that sequences each operation over the list datapath.
module oale_ctrl
  import oale_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_INS_SH = 3'd2;
  localparam logic [2:0] ST_INS_WR = 3'd3;
  localparam logic [2:0] ST_DEL_SH = 3'd4;
  localparam logic [2:0] ST_LOC    = 3'd5;
  localparam logic [2:0] ST_GET    = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = rst_ni && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.idx_op = IDX_HOLD;
    cmd_o.wr_sel = WA_IDX_P1;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status_i.kind)
          KIND_INSERT: begin
            if (!status_i.ins_ok) begin
              state_d = ST_DONE;
            end else if (status_i.ins_moves) begin
              cmd_o.idx_op = IDX_TOP;
              cmd_o.rd_en  = 1'b1;
              state_d      = ST_INS_SH;
            end else begin
              state_d = ST_INS_WR;
            end
          end
          KIND_DELETE: begin
            if (!status_i.del_ok) begin
              state_d = ST_DONE;
            end else if (status_i.del_moves) begin
              cmd_o.idx_op = IDX_POS;
              cmd_o.rd_en  = 1'b1;
              state_d      = ST_DEL_SH;
            end else begin
              cmd_o.cnt_dec = 1'b1;
              cmd_o.set_ok  = 1'b1;
              state_d       = ST_DONE;
            end
          end
          KIND_LOCATE: begin
            cmd_o.set_ok = 1'b1;
            if (status_i.cnt_zero) begin
              state_d = ST_DONE;
            end else begin
              cmd_o.idx_op = IDX_ZERO;
              cmd_o.rd_en  = 1'b1;
              state_d      = ST_LOC;
            end
          end
          default: begin
            if (!status_i.get_ok) begin
              cmd_o.set_fail_rd = 1'b1;
              state_d           = ST_DONE;
            end else begin
              cmd_o.idx_op = IDX_POS_M1;
              cmd_o.rd_en  = 1'b1;
              state_d      = ST_GET;
            end
          end
        endcase
      end
      ST_INS_SH: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WA_IDX_P1;
        if (status_i.idx_at_pos_m1) begin
          state_d = ST_INS_WR;
        end else begin
          cmd_o.idx_op = IDX_DEC;
          cmd_o.rd_en  = 1'b1;
        end
      end
      ST_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WA_POS_M1;
        cmd_o.cnt_inc = 1'b1;
        cmd_o.set_ok  = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DEL_SH: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WA_IDX_M1;
        if (status_i.idx_at_top) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.set_ok  = 1'b1;
          state_d       = ST_DONE;
        end else begin
          cmd_o.idx_op = IDX_INC;
          cmd_o.rd_en  = 1'b1;
        end
      end
      ST_LOC: begin
        if (status_i.match) begin
          cmd_o.set_found = 1'b1;
          state_d         = ST_DONE;
        end else if (status_i.idx_at_top) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.idx_op = IDX_INC;
          cmd_o.rd_en  = 1'b1;
        end
      end
      ST_GET: begin
        cmd_o.set_rd = 1'b1;
        cmd_o.set_ok = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> status_i.out_free)
    else $error("A result was published over one that was not yet taken.");

endmodule

/* rtl/ordered_array_list_engine_core.sv */
// Top level of the ordered list engine: stream ports, controller and datapath.
//
// The engine keeps an ordered list of up to 64 signed 32-bit values and runs
// one operation per input transfer: insert at a 1-based position, delete at a
// position, locate the first position of a value, or get the value at a
// position. Every input transfer yields exactly one output transfer.
// The slave channel takes the operation in tuser and the position and value in
// tdata. The master channel returns ok, found position, read value, list length
// and an empty flag. One item is processed at a time.
// For position p, an insert that moves entries shifts the entries from the
// top down to p up by one place, then writes the value; an append only writes
// the value. A delete that moves entries shifts the entries above p down by
// one place; a rejected operation or a delete of the last entry moves no
// entry. A locate reads from the first entry until a match or the last entry,
// and a get reads the entry at p. The slave side is ready again in the cycle
// in which the result turns valid, so a new item waits for the last result.
// The element memory moves or compares one entry per cycle.
// Reset empties the list at once and drops any pending result. If the receiver
// stalls, the result is held in the output register; the next item is still
// accepted and runs up to its own result, which then waits for the first.
module ordered_array_list_engine_core
  import oale_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata: position [6:0], value [38:7], zero [39]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: kind [1:0]
  input  logic [KIND_W-1:0]     s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata: ok [0], found_position [7:1], read_value [39:8],
  //        list_length [46:40], is_empty [47]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  cmd_t    cmd;
  status_t status;

  oale_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  oale_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .kind_i      (s_axis_tuser_i),
    .position_i  (s_axis_tdata_i[POS_W-1:0]),
    .value_i     (s_axis_tdata_i[POS_W+VAL_W-1:POS_W]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

/* test/testbench.sv */
// Self-checking testbench for the ordered list engine with directed and random operations.
module testbench
  import oale_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] found;
    logic [VAL_W-1:0] rd;
    logic [6:0]       len;
    logic             empty;
  } list_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [KIND_W-1:0]     s_axis_tuser_i = KIND_INSERT;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  logic [VAL_W-1:0] list_entries[$];
  list_result_t     pending_results[$];
  int               error_count = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;

  ordered_array_list_engine_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic list_result_t apply_list_op(logic [KIND_W-1:0] kind,
                                                 logic [POS_W-1:0] pos,
                                                 logic [VAL_W-1:0] val);
    list_result_t res;
    int p;
    int n;
    res = '0;
    p = pos;
    n = list_entries.size();
    case (kind)
      KIND_INSERT: begin
        if (p >= 1 && p <= n + 1 && n < CAPACITY) begin
          list_entries.insert(p - 1, val);
          res.ok = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (p >= 1 && p <= n) begin
          list_entries.delete(p - 1);
          res.ok = 1'b1;
        end
      end
      KIND_LOCATE: begin
        res.ok = 1'b1;
        for (int j = 0; j < n; j++) begin
          if (res.found == 0 && list_entries[j] == val) res.found = POS_W'(j + 1);
        end
      end
      default: begin
        if (p >= 1 && p <= n) begin
          res.rd = list_entries[p - 1];
          res.ok = 1'b1;
        end else begin
          res.rd = GET_FAIL_VALUE;
        end
      end
    endcase
    res.len   = 7'(list_entries.size());
    res.empty = (list_entries.size() == 0);
    return res;
  endfunction

  always @(posedge clk_i) begin
    list_result_t exp_res;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no result expected: tdata %h", m_axis_tdata_o);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tdata_o[0] !== exp_res.ok) begin
          $error("ok: expected %0d, got %0d", exp_res.ok, m_axis_tdata_o[0]);
          error_count++;
        end
        if (m_axis_tdata_o[7:1] !== exp_res.found) begin
          $error("found_position: expected %0d, got %0d", exp_res.found, m_axis_tdata_o[7:1]);
          error_count++;
        end
        if (m_axis_tdata_o[39:8] !== exp_res.rd) begin
          $error("read_value: expected %0d, got %0d",
                 $signed(exp_res.rd), $signed(m_axis_tdata_o[39:8]));
          error_count++;
        end
        if (m_axis_tdata_o[46:40] !== exp_res.len) begin
          $error("list_length: expected %0d, got %0d", exp_res.len, m_axis_tdata_o[46:40]);
          error_count++;
        end
        if (m_axis_tdata_o[47] !== exp_res.empty) begin
          $error("is_empty: expected %0d, got %0d", exp_res.empty, m_axis_tdata_o[47]);
          error_count++;
        end
      end
    end
  end

  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                         input logic [VAL_W-1:0] val);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {1'b0, val, pos};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(apply_list_op(kind, pos, val));
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_list();
    send_op(KIND_GET, 7'd1, 32'd0);
    send_op(KIND_GET, 7'd0, 32'd0);
    send_op(KIND_DELETE, 7'd1, 32'd0);
    send_op(KIND_LOCATE, 7'd0, 32'd0);
    send_op(KIND_INSERT, 7'd0, 32'd5);
    send_op(KIND_INSERT, 7'd2, 32'd5);
  endtask

  task automatic test_basic_ops();
    send_op(KIND_INSERT, 7'd1, 32'h8000_0000);
    send_op(KIND_INSERT, 7'd2, 32'h7FFF_FFFF);
    send_op(KIND_INSERT, 7'd1, 32'h0000_0000);
    send_op(KIND_INSERT, 7'd2, 32'hFFFF_FFFF);
    send_op(KIND_INSERT, 7'd3, 32'hFFFF_FFFF);
    send_op(KIND_LOCATE, 7'd127, 32'hFFFF_FFFF);
    send_op(KIND_LOCATE, 7'd0, 32'h7FFF_FFFF);
    send_op(KIND_LOCATE, 7'd0, 32'h1234_5678);
    send_op(KIND_GET, 7'd1, 32'hFFFF_FFFF);
    send_op(KIND_GET, 7'd5, 32'd0);
    send_op(KIND_GET, 7'd6, 32'd0);
    send_op(KIND_GET, 7'd127, 32'd0);
    send_op(KIND_INSERT, 7'd7, 32'd1);
    send_op(KIND_DELETE, 7'd0, 32'd0);
    send_op(KIND_DELETE, 7'd6, 32'd0);
    send_op(KIND_DELETE, 7'd5, 32'd0);
    send_op(KIND_DELETE, 7'd2, 32'd0);
    send_op(KIND_DELETE, 7'd1, 32'd0);
    drain_results();
  endtask

  task automatic test_full_list();
    while (list_entries.size() < CAPACITY) begin
      send_op(KIND_INSERT, POS_W'($urandom_range(list_entries.size() + 1, 1)), $urandom);
    end
    send_op(KIND_INSERT, 7'd65, 32'd9);
    send_op(KIND_INSERT, 7'd1, 32'd9);
    send_op(KIND_INSERT, 7'd64, 32'd9);
    send_op(KIND_LOCATE, 7'd0, list_entries[CAPACITY-1]);
    send_op(KIND_GET, 7'd64, 32'd0);
    send_op(KIND_GET, 7'd65, 32'd0);
    send_op(KIND_DELETE, 7'd65, 32'd0);
    while (list_entries.size() > 0) begin
      send_op(KIND_DELETE, POS_W'($urandom_range(list_entries.size(), 1)), 32'd0);
    end
    drain_results();
  endtask

  task automatic random_op(input int grow_pct);
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    int n;
    n = list_entries.size();
    if ($urandom_range(99) < grow_pct) begin
      kind = KIND_INSERT;
    end else begin
      case ($urandom_range(2))
        0:       kind = KIND_DELETE;
        1:       kind = KIND_LOCATE;
        default: kind = KIND_GET;
      endcase
    end
    case ($urandom_range(9))
      0:       pos = POS_W'($urandom_range(127));
      1:       pos = POS_W'(n + 1);
      2:       pos = POS_W'(n);
      default: pos = POS_W'($urandom_range(n + 1, 1));
    endcase
    if (kind == KIND_LOCATE && n > 0 && $urandom_range(1) == 1) begin
      val = list_entries[$urandom_range(n - 1)];
    end else if ($urandom_range(1) == 1) begin
      val = VAL_W'($urandom_range(7));
    end else begin
      val = $urandom;
    end
    send_op(kind, pos, val);
  endtask

  task automatic test_random(input int send_pct, input int recv_pct, input int count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      random_op(((i / 40) % 2 == 0) ? 65 : 20);
      if (i == count / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_random(0, 0, 275);
    test_random(61, 0, 275);
    test_random(0, 61, 275);
    test_random(37, 37, 275);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain_results();
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
